[hw/rtl/m3i_pkg.sv]
`default_nettype none
package m3i_pkg;

   localparam int DATA_WIDTH_DEF = 32;
   localparam int FRAC_BITS_DEF  = 16;
   localparam int NUM_ENTRIES    = 9;
   localparam int NUM_COLS       = 3;

   // cofactor k = e[PA]*e[PS] - e[QA]*e[QT]
   localparam int PA [NUM_ENTRIES] = '{4, 7, 1, 5, 8, 2, 3, 6, 0};
   localparam int PS [NUM_ENTRIES] = '{8, 2, 5, 6, 0, 3, 7, 1, 4};
   localparam int QA [NUM_ENTRIES] = '{7, 1, 4, 8, 2, 5, 6, 0, 3};
   localparam int QT [NUM_ENTRIES] = '{5, 8, 2, 3, 6, 0, 4, 7, 1};

   // last column entries, dotted with the third cofactor row for the determinant
   localparam int COL2 [NUM_COLS] = '{2, 5, 8};

   typedef struct packed {
      logic neg;
      logic over;
      logic zero;
   } flag_type;

endpackage
`default_nettype wire

[hw/rtl/m3i_cofactor.sv]
`default_nettype none
module m3i_cofactor #(
   parameter int W = m3i_pkg::DATA_WIDTH_DEF
) (
   input  wire logic                clock,
   input  wire logic                adv,
   input  wire logic signed [W-1:0] e_i    [m3i_pkg::NUM_ENTRIES],
   output logic signed [2*W:0]      cof_o  [m3i_pkg::NUM_ENTRIES],
   output logic signed [W-1:0]      ecol_o [m3i_pkg::NUM_COLS]
);
   import m3i_pkg::*;

   localparam int CW = 2 * W + 1;

   logic signed [2*W-1:0] pa_ff [NUM_ENTRIES];
   logic signed [2*W-1:0] pb_ff [NUM_ENTRIES];
   logic signed [W-1:0]   ea_ff [NUM_COLS];
   logic signed [CW-1:0]  cof_ff [NUM_ENTRIES];
   logic signed [W-1:0]   eb_ff [NUM_COLS];

   always_ff @(posedge clock) begin
      if (adv) begin
         for (int k = 0; k < NUM_ENTRIES; k++) begin
            pa_ff[k]  <= e_i[PA[k]] * e_i[PS[k]];
            pb_ff[k]  <= e_i[QA[k]] * e_i[QT[k]];
            cof_ff[k] <= CW'(pa_ff[k]) - CW'(pb_ff[k]);
         end
         for (int j = 0; j < NUM_COLS; j++) begin
            ea_ff[j] <= e_i[COL2[j]];
            eb_ff[j] <= ea_ff[j];
         end
      end
   end

   assign cof_o  = cof_ff;
   assign ecol_o = eb_ff;

endmodule
`default_nettype wire

[hw/rtl/m3i_det.sv]
`default_nettype none
module m3i_det #(
   parameter int W = m3i_pkg::DATA_WIDTH_DEF
) (
   input  wire logic                clock,
   input  wire logic                adv,
   input  wire logic signed [2*W:0] cof_i  [m3i_pkg::NUM_ENTRIES],
   input  wire logic signed [W-1:0] ecol_i [m3i_pkg::NUM_COLS],
   output logic signed [2*W:0]      cof_o  [m3i_pkg::NUM_ENTRIES],
   output logic signed [3*W+2:0]    det_o
);
   import m3i_pkg::*;

   localparam int CW = 2 * W + 1;
   localparam int DW = 3 * W + 3;

   logic signed [CW-1:0] lo_ff  [NUM_COLS];
   logic signed [CW-1:0] hi_ff  [NUM_COLS];
   logic signed [CW-1:0] cofc_ff [NUM_ENTRIES];
   logic signed [CW-1:0] cofd_ff [NUM_ENTRIES];
   logic signed [DW-1:0] det_ff;
   logic signed [DW-1:0] det_in;

   // cofactor split into unsigned low word and signed high part
   always_ff @(posedge clock) begin
      if (adv) begin
         for (int j = 0; j < NUM_COLS; j++) begin
            lo_ff[j] <= $signed({1'b0, cof_i[6+j][W-1:0]}) * ecol_i[j];
            hi_ff[j] <= $signed(cof_i[6+j][CW-1:W]) * ecol_i[j];
         end
         cofc_ff <= cof_i;
         cofd_ff <= cofc_ff;
         det_ff  <= det_in;
      end
   end

   always_comb begin
      det_in = '0;
      for (int j = 0; j < NUM_COLS; j++) begin
         det_in = det_in + (DW'(hi_ff[j]) <<< W) + DW'(lo_ff[j]);
      end
   end

   assign cof_o = cofd_ff;
   assign det_o = det_ff;

endmodule
`default_nettype wire

[hw/rtl/m3i_div_lane.sv]
`default_nettype none
module m3i_div_lane #(
   parameter int W = m3i_pkg::DATA_WIDTH_DEF,
   parameter int F = m3i_pkg::FRAC_BITS_DEF
) (
   input  wire logic                  clock,
   input  wire logic                  adv,
   input  wire logic signed [2*W:0]   cof_i,
   input  wire logic signed [3*W+2:0] det_i,
   output logic signed [W-1:0]        value_o,
   output logic                       sat_o
);
   import m3i_pkg::*;

   localparam int CW   = 2 * W + 1;
   localparam int DW   = 3 * W + 3;
   localparam int RW_A = DW + W + 1;
   localparam int RW_B = CW + 2 * F + 2;
   localparam int RW   = (RW_A > RW_B) ? RW_A : RW_B;
   localparam logic [W-1:0] HALF = {1'b1, {(W-1){1'b0}}};

   logic [CW-1:0] cof_u;
   logic [DW-1:0] det_u;
   logic [CW-1:0] an_ff;
   logic [DW-1:0] ad_ff;
   flag_type      f0_ff;
   flag_type      f0_in;

   logic [RW-1:0] r_ff [W+1];
   logic [RW-1:0] d_ff [W+1];
   logic [W-1:0]  q_ff [W+1];
   flag_type      f_ff [W+1];

   logic [RW-1:0] n_in;
   logic [RW-1:0] d_in;
   flag_type      f1_in;

   logic [W-1:0]        lim;
   logic [W-1:0]        mag;
   logic                sat_c;
   logic signed [W-1:0] value_ff;
   logic                sat_ff;

   assign cof_u = cof_i;
   assign det_u = det_i;

   always_comb begin
      f0_in      = '0;
      f0_in.neg  = cof_i[CW-1] ^ det_i[DW-1];
      f0_in.zero = (det_i == '0);
   end

   // magnitudes
   always_ff @(posedge clock) begin
      if (adv) begin
         an_ff <= cof_i[CW-1] ? (~cof_u + 1'b1) : cof_u;
         ad_ff <= det_i[DW-1] ? (~det_u + 1'b1) : det_u;
         f0_ff <= f0_in;
      end
   end

   // rounded quotient (2|cof|*2^2F + |det|) / (2|det|)
   always_comb begin
      n_in       = (RW'(an_ff) << (2 * F + 1)) + RW'(ad_ff);
      d_in       = RW'(ad_ff) << 1;
      f1_in      = f0_ff;
      f1_in.over = (n_in >= (d_in << W));
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         r_ff[0] <= n_in;
         d_ff[0] <= d_in;
         q_ff[0] <= '0;
         f_ff[0] <= f1_in;
      end
   end

   // restoring division, one quotient bit per stage
   for (genvar s = 0; s < W; s++) begin : g_div
      localparam int SH = W - 1 - s;
      logic [RW:0] t;

      assign t = {1'b0, r_ff[s]} - ({1'b0, d_ff[s]} << SH);

      always_ff @(posedge clock) begin
         if (adv) begin
            r_ff[s+1] <= t[RW] ? r_ff[s] : t[RW-1:0];
            d_ff[s+1] <= d_ff[s];
            q_ff[s+1] <= {q_ff[s][W-2:0], ~t[RW]};
            f_ff[s+1] <= f_ff[s];
         end
      end
   end

   always_comb begin
      lim   = f_ff[W].neg ? HALF : (HALF - 1'b1);
      sat_c = f_ff[W].over || (q_ff[W] > lim);
      mag   = sat_c ? lim : q_ff[W];
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         if (f_ff[W].zero) begin
            value_ff <= '0;
            sat_ff   <= 1'b0;
         end else begin
            value_ff <= f_ff[W].neg ? $signed(~mag + 1'b1) : $signed(mag);
            sat_ff   <= sat_c;
         end
      end
   end

   assign value_o = value_ff;
   assign sat_o   = sat_ff;

endmodule
`default_nettype wire

[hw/rtl/matrix3_inverse.sv]
// 3x3 matrix inverse on signed fixed point (Q16.16 by default). One matrix
// enters per cycle while rsp_ready does not stall the output. The pipeline is
// DATA_WIDTH+7 registers deep. The bulk of that depth is the nine divider
// lanes, each a restoring divider that resolves one quotient bit per pipeline
// stage; the cofactor and determinant stages add four registers, the divider
// setup two and the rounding/saturation output register one. A stall on
// rsp_ready freezes the whole pipeline. A zero determinant gives all-zero
// entries with rsp_singular set; clipped entries set rsp_saturated.
`default_nettype none
module matrix3_inverse #(
   parameter int DATA_WIDTH = m3i_pkg::DATA_WIDTH_DEF,
   parameter int FRAC_BITS  = m3i_pkg::FRAC_BITS_DEF
) (
   input  wire logic                         clock,
   input  wire logic                         reset,
   input  wire logic                         req_valid,
   output logic                              req_ready,
   input  wire logic signed [DATA_WIDTH-1:0] req_in_r0c0,
   input  wire logic signed [DATA_WIDTH-1:0] req_in_r0c1,
   input  wire logic signed [DATA_WIDTH-1:0] req_in_r0c2,
   input  wire logic signed [DATA_WIDTH-1:0] req_in_r1c0,
   input  wire logic signed [DATA_WIDTH-1:0] req_in_r1c1,
   input  wire logic signed [DATA_WIDTH-1:0] req_in_r1c2,
   input  wire logic signed [DATA_WIDTH-1:0] req_in_r2c0,
   input  wire logic signed [DATA_WIDTH-1:0] req_in_r2c1,
   input  wire logic signed [DATA_WIDTH-1:0] req_in_r2c2,
   output logic                              rsp_valid,
   input  wire logic                         rsp_ready,
   output logic signed [DATA_WIDTH-1:0]      rsp_out_r0c0,
   output logic signed [DATA_WIDTH-1:0]      rsp_out_r0c1,
   output logic signed [DATA_WIDTH-1:0]      rsp_out_r0c2,
   output logic signed [DATA_WIDTH-1:0]      rsp_out_r1c0,
   output logic signed [DATA_WIDTH-1:0]      rsp_out_r1c1,
   output logic signed [DATA_WIDTH-1:0]      rsp_out_r1c2,
   output logic signed [DATA_WIDTH-1:0]      rsp_out_r2c0,
   output logic signed [DATA_WIDTH-1:0]      rsp_out_r2c1,
   output logic signed [DATA_WIDTH-1:0]      rsp_out_r2c2,
   output logic                              rsp_singular,
   output logic                              rsp_saturated
);
   import m3i_pkg::*;

   localparam int W       = DATA_WIDTH;
   localparam int CW      = 2 * W + 1;
   localparam int DW      = 3 * W + 3;
   localparam int LAT     = W + 7;
   localparam int SNG_LEN = W + 3;

   logic                 adv;
   logic [LAT-1:0]       vld_ff;
   logic [LAT-1:0]       vld_in;
   logic [SNG_LEN-1:0]   sng_ff;

   logic signed [W-1:0]  e      [NUM_ENTRIES];
   logic signed [CW-1:0] cof_b  [NUM_ENTRIES];
   logic signed [W-1:0]  ecol_b [NUM_COLS];
   logic signed [CW-1:0] cof_d  [NUM_ENTRIES];
   logic signed [DW-1:0] det_d;
   logic signed [W-1:0]  val    [NUM_ENTRIES];
   logic [NUM_ENTRIES-1:0] sat;

   assign adv       = ~vld_ff[LAT-1] | rsp_ready;
   assign req_ready = adv;
   assign rsp_valid = vld_ff[LAT-1];

   assign vld_in = {vld_ff[LAT-2:0], req_valid};

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (adv) begin
         vld_ff <= vld_in;
      end
   end

   // singular flag follows the divider lanes
   always_ff @(posedge clock) begin
      if (adv) begin
         sng_ff <= {sng_ff[SNG_LEN-2:0], (det_d == '0)};
      end
   end

   assign e[0] = req_in_r0c0;
   assign e[1] = req_in_r0c1;
   assign e[2] = req_in_r0c2;
   assign e[3] = req_in_r1c0;
   assign e[4] = req_in_r1c1;
   assign e[5] = req_in_r1c2;
   assign e[6] = req_in_r2c0;
   assign e[7] = req_in_r2c1;
   assign e[8] = req_in_r2c2;

   m3i_cofactor #(.W(W)) u_cofactor (
      .clock  (clock),
      .adv    (adv),
      .e_i    (e),
      .cof_o  (cof_b),
      .ecol_o (ecol_b)
   );

   m3i_det #(.W(W)) u_det (
      .clock  (clock),
      .adv    (adv),
      .cof_i  (cof_b),
      .ecol_i (ecol_b),
      .cof_o  (cof_d),
      .det_o  (det_d)
   );

   for (genvar k = 0; k < NUM_ENTRIES; k++) begin : g_lane
      m3i_div_lane #(.W(W), .F(FRAC_BITS)) u_lane (
         .clock   (clock),
         .adv     (adv),
         .cof_i   (cof_d[k]),
         .det_i   (det_d),
         .value_o (val[k]),
         .sat_o   (sat[k])
      );
   end

   assign rsp_out_r0c0  = val[0];
   assign rsp_out_r0c1  = val[1];
   assign rsp_out_r0c2  = val[2];
   assign rsp_out_r1c0  = val[3];
   assign rsp_out_r1c1  = val[4];
   assign rsp_out_r1c2  = val[5];
   assign rsp_out_r2c0  = val[6];
   assign rsp_out_r2c1  = val[7];
   assign rsp_out_r2c2  = val[8];
   assign rsp_singular  = sng_ff[SNG_LEN-1];
   assign rsp_saturated = |sat;

   a_singular_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_singular |-> !rsp_saturated && rsp_out_r0c0 == '0 &&
         rsp_out_r1c1 == '0 && rsp_out_r2c2 == '0 && rsp_out_r0c2 == '0 &&
         rsp_out_r2c0 == '0)
      else $error("singular result not cleared");

   a_ready_free: assert property (@(posedge clock) disable iff (reset)
      !rsp_valid |-> req_ready)
      else $error("input stalled with empty output");

   a_enter: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> vld_ff[0])
      else $error("accepted word lost at pipeline entry");

endmodule
`default_nettype wire
